// ===== hdl/vm_call_frame_stack_core_macros.svh =====
// Assertion macros for the call frame stack core.
// No dependencies; included by the files that carry assertions.
`ifndef VM_CALL_FRAME_STACK_CORE_MACROS_SVH
`define VM_CALL_FRAME_STACK_CORE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define VMCFS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vmcfs assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define VMCFS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vmcfs assertion failed: next-cycle implication");

`endif

// ===== hdl/vmcfs_pkg.sv =====
// Shared types and constants of the call frame stack core.
// No dependencies; imported by vmcfs_decode and vm_call_frame_stack_core.
package vmcfs_pkg;

    localparam int DEPTH_DEF   = 1024;
    localparam int LIMIT_W     = 11;
    localparam int LIMIT_RST   = 1024;
    localparam int FRAME_WORDS = 2;
    localparam int MODE_W      = 3;
    localparam int SLOT_W      = 10;
    localparam int WORD_W      = 32;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH   = 3'd0,
        MODE_POP    = 3'd1,
        MODE_PUSHF  = 3'd2,
        MODE_POPF   = 3'd3,
        MODE_LOAD   = 3'd4,
        MODE_STORE  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PF2,
        S_PP2,
        S_RESP
    } t_state;

    // decode of one accepted item
    typedef struct packed {
        t_status status;
        logic    mem_en;
        logic    mem_we;
        logic    wr_pc;
        logic    upd_top;
        logic    sel_q;
        logic    to_pf2;
        logic    to_pp2;
    } t_dec;

endpackage

// ===== hdl/vmcfs_decode.sv =====
// Operation decode: bounds checks, first memory access and new top pointer.
// Depends on vmcfs_pkg.
module vmcfs_decode import vmcfs_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int PW    = $clog2(DEPTH + 1)
) (
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [PW-1:0]      i_top,
    input  logic [PW-1:0]      i_fp,
    input  logic [LIMIT_W-1:0] i_limit,
    output t_dec               o_dec,
    output logic [AW-1:0]      o_addr,
    output logic [PW-1:0]      o_new_top,
    output logic [PW-1:0]      o_frame
);

    localparam int CW = ((PW > LIMIT_W) ? PW : LIMIT_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [CW-1:0] top_c, fp_c, slot_c, limit_c, lim_c;
    logic [CW-1:0] frame_c, pushf_end, arg_c, arg_addr;

    always_comb begin
        top_c     = CW'(i_top);
        fp_c      = CW'(i_fp);
        slot_c    = CW'(i_slot);
        limit_c   = CW'(i_limit);
        lim_c     = (limit_c > DEPTH_C) ? DEPTH_C : limit_c;
        frame_c   = top_c + slot_c;
        pushf_end = frame_c + CW'(FRAME_WORDS);
        arg_c     = slot_c + CW'(1);
        arg_addr  = fp_c - arg_c;
    end

    always_comb begin
        o_dec     = '{status: ST_OK, default: 1'b0};
        o_addr    = '0;
        o_new_top = i_top;
        o_frame   = '0;
        unique case (t_mode'(i_mode))
            MODE_PUSH: begin
                if (top_c >= lim_c) begin
                    o_dec.status = ST_OVER;
                end else begin
                    o_dec.mem_en  = 1'b1;
                    o_dec.mem_we  = 1'b1;
                    o_dec.upd_top = 1'b1;
                    o_addr        = top_c[AW-1:0];
                    o_new_top     = i_top + PW'(1);
                end
            end
            MODE_POP: begin
                if (top_c == '0) begin
                    o_dec.status = ST_UNDER;
                end else begin
                    o_dec.mem_en  = 1'b1;
                    o_dec.upd_top = 1'b1;
                    o_dec.sel_q   = 1'b1;
                    o_new_top     = i_top - PW'(1);
                    o_addr        = o_new_top[AW-1:0];
                end
            end
            MODE_PUSHF: begin
                if (pushf_end > lim_c) begin
                    o_dec.status = ST_OVER;
                end else begin
                    // pc word now, saved frame pointer next cycle
                    o_dec.mem_en  = 1'b1;
                    o_dec.mem_we  = 1'b1;
                    o_dec.wr_pc   = 1'b1;
                    o_dec.upd_top = 1'b1;
                    o_dec.to_pf2  = 1'b1;
                    o_addr        = frame_c[AW-1:0];
                    o_new_top     = pushf_end[PW-1:0];
                    o_frame       = frame_c[PW-1:0];
                end
            end
            MODE_POPF: begin
                if (fp_c <= slot_c) begin
                    o_dec.status = ST_UNDER;
                end else begin
                    // frame pointer may sit at DEPTH: its word reads as zero
                    o_dec.mem_en  = (fp_c < DEPTH_C);
                    o_dec.upd_top = 1'b1;
                    o_dec.to_pp2  = 1'b1;
                    o_addr        = fp_c[AW-1:0];
                    o_new_top     = i_fp - PW'(i_slot);
                end
            end
            MODE_LOAD: begin
                if (arg_c > fp_c) begin
                    o_dec.status = ST_UNDER;
                end else begin
                    o_dec.mem_en = 1'b1;
                    o_dec.sel_q  = 1'b1;
                    o_addr       = arg_addr[AW-1:0];
                end
            end
            MODE_STORE: begin
                if (arg_c > fp_c) begin
                    o_dec.status = ST_UNDER;
                end else begin
                    o_dec.mem_en = 1'b1;
                    o_dec.mem_we = 1'b1;
                    o_addr       = arg_addr[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== hdl/vm_call_frame_stack_core.sv =====
// Call frame stack core: sequencer, single-port stack memory, output register.
// Depends on vmcfs_pkg, vmcfs_decode and vm_call_frame_stack_core_macros.svh.
//
// Usage:
//   Input channel i_valid/o_ready carries one operation (i_mode, i_value,
//   i_slot, i_pc). Output channel o_valid/i_ready returns one result per
//   operation (o_data, o_status), in order.
//   i_cfg_we/i_cfg_data write stack_limit; write it only while idle.
//   Push, pop, load, store, errors and unused modes go from S_IDLE to S_RESP;
//   push frame and pop frame pass through S_PF2 or S_PP2 between. The single
//   memory port sets this: a frame operation touches two words, one per cycle.
//   o_valid rises when S_RESP loads the output register, once it is free; a
//   new operation is accepted only in S_IDLE, after the last one leaves S_RESP.
//   The output register lets the next operation be accepted while a result
//   waits; if the receiver stalls longer, the core holds its finished result
//   and drops o_ready until the output register frees.
//   Reset (synchronous, active low) clears pointers and sets the limit to
//   1024, then a clearing pass writes zero to every memory word, one word a
//   cycle, with o_ready low. Config writes are taken meanwhile.
module vm_call_frame_stack_core import vmcfs_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [MODE_W-1:0]  i_mode,
    input  logic [WORD_W-1:0]  i_value,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic [WORD_W-1:0]  i_pc,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [WORD_W-1:0]  o_data,
    output logic [1:0]         o_status,
    input  logic               i_cfg_we,
    input  logic [LIMIT_W-1:0] i_cfg_data
);

`include "vm_call_frame_stack_core_macros.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(DEPTH + 1);

    t_state r_state, n_state;

    logic [PW-1:0]      r_top, r_fp, r_frame;
    logic [LIMIT_W-1:0] r_limit;
    logic [AW-1:0]      r_clr;
    logic [WORD_W-1:0]  r_data, r_q;
    t_status            r_status;
    logic               r_sel_q, r_qok, r_popf;
    logic               r_ov;
    logic [WORD_W-1:0]  r_odata;
    logic [1:0]         r_ostatus;

    t_dec               dec;
    logic [AW-1:0]      dec_addr;
    logic [PW-1:0]      dec_top, dec_frame;

    logic               in_xfer, out_free;
    logic               mem_en, mem_we;
    logic [AW-1:0]      mem_addr;
    logic [WORD_W-1:0]  mem_wdata;
    logic [PW:0]        fp_next;
    logic               fp_next_ok;
    logic [WORD_W-1:0]  q_val, resp_data, old_fp;
    logic [PW-1:0]      fp_restored;

    logic [WORD_W-1:0]  mem [DEPTH];

    vmcfs_decode #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .PW    (PW)
    ) u_decode (
        .i_mode    (i_mode),
        .i_slot    (i_slot),
        .i_top     (r_top),
        .i_fp      (r_fp),
        .i_limit   (r_limit),
        .o_dec     (dec),
        .o_addr    (dec_addr),
        .o_new_top (dec_top),
        .o_frame   (dec_frame)
    );

    assign o_ready   = (r_state == S_IDLE);
    assign in_xfer   = i_valid && o_ready;
    assign out_free  = !r_ov || i_ready;
    assign o_valid   = r_ov;
    assign o_data    = r_odata;
    assign o_status  = r_ostatus;

    assign fp_next    = {1'b0, r_fp} + (PW + 1)'(1);
    assign fp_next_ok = (fp_next < (PW + 1)'(DEPTH));
    assign q_val      = r_qok ? r_q : '0;
    assign resp_data  = r_sel_q ? q_val : r_data;
    assign old_fp     = q_val;
    assign fp_restored = (old_fp > WORD_W'(DEPTH)) ? PW'(DEPTH) : old_fp[PW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (in_xfer) begin
                    priority if (dec.to_pf2) n_state = S_PF2;
                    else if (dec.to_pp2)     n_state = S_PP2;
                    else                     n_state = S_RESP;
                end
            end
            S_PF2:  n_state = S_RESP;
            S_PP2:  n_state = S_RESP;
            S_RESP: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory port
    always_comb begin
        mem_en    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_en   = 1'b1;
                mem_we   = 1'b1;
                mem_addr = r_clr;
            end
            S_IDLE: begin
                mem_en    = in_xfer && dec.mem_en;
                mem_we    = dec.mem_we;
                mem_addr  = dec_addr;
                mem_wdata = dec.wr_pc ? i_pc : i_value;
            end
            S_PF2: begin
                // saved frame pointer goes just above the pc word
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = r_frame[AW-1:0] + AW'(1);
                mem_wdata = WORD_W'(r_fp);
            end
            S_PP2: begin
                mem_en   = fp_next_ok;
                mem_addr = fp_next[AW-1:0];
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_en) begin
            if (mem_we) begin
                mem[mem_addr] <= mem_wdata;
            end else begin
                r_q <= mem[mem_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_top   <= '0;
            r_fp    <= '0;
            r_limit <= LIMIT_W'(LIMIT_RST);
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_limit <= i_cfg_data;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            // in S_RESP the output register is refilled below instead
            if (r_ov && i_ready && (r_state != S_RESP)) r_ov <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (dec.upd_top) r_top <= dec_top;
                        r_frame  <= dec_frame;
                        r_status <= dec.status;
                        r_sel_q  <= dec.sel_q;
                        r_qok    <= dec.mem_en && !dec.mem_we;
                        r_popf   <= dec.to_pp2;
                        r_data   <= '0;
                    end
                end
                S_PF2: begin
                    r_fp <= r_frame;
                end
                S_PP2: begin
                    // saved pc arrives now; old frame pointer next cycle
                    r_data <= q_val;
                    r_qok  <= fp_next_ok;
                end
                S_RESP: begin
                    // q holds while stalled, so repeating this is harmless
                    if (r_popf) r_fp <= fp_restored;
                    if (out_free) begin
                        r_ov      <= 1'b1;
                        r_odata   <= resp_data;
                        r_ostatus <= r_status;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `VMCFS_ASSERT_IMP(a_top_in_range, i_clk, i_rst_n, 1'b1, r_top <= PW'(DEPTH))
    `VMCFS_ASSERT_IMP(a_fp_in_range, i_clk, i_rst_n, 1'b1, r_fp <= PW'(DEPTH))
    `VMCFS_ASSERT_IMP(a_no_mem_in_resp, i_clk, i_rst_n, r_state == S_RESP, !mem_en)
    `VMCFS_ASSERT_NXT(a_pushf_second, i_clk, i_rst_n, in_xfer && dec.to_pf2, r_state == S_PF2)
    `VMCFS_ASSERT_IMP(a_out_from_resp, i_clk, i_rst_n, $rose(r_ov), $past(r_state) == S_RESP)

endmodule
